>>> design/ffca_pkg.sv
package ffca_pkg;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_ERASE  = 2'd1,
        REQ_DEFRAG = 2'd2
    } t_req_e;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status_e;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ASCAN,
        S_AFILL,
        S_ESCAN,
        S_DSCAN,
        S_DZERO,
        S_RESP
    } t_state_e;

    localparam int unsigned SIZE_W = 8;
    localparam int unsigned BID_W  = 16;
    localparam int unsigned STAT_W = 2;

endpackage

>>> design/ffca_if.sv
interface ffca_req_if import ffca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [SIZE_W-1:0] block_size;
    logic [BID_W-1:0]  block_id;

    modport source (output valid, output req_type, output block_size, output block_id,
                    input ready);
    modport sink   (input valid, input req_type, input block_size, input block_id,
                    output ready);
endinterface

interface ffca_rsp_if import ffca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BID_W-1:0]  given_id;

    modport source (output valid, output status, output given_id, input ready);
    modport sink   (input valid, input status, input given_id, output ready);
endinterface

>>> design/ffca_cell_ram.sv
module ffca_cell_ram #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7,
    parameter int unsigned DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/first_fit_cell_allocator.sv
// First-fit cell allocator with compaction.
// Requests come in on i_req (req_type, block_size, block_id); results leave on
// o_rsp (status, given_id). One request is worked on at a time; i_req.ready is
// high while the block is idle. The owner table sits in a one-port-read,
// one-port-write RAM, scanned one cell per cycle; with M = memory_cells:
//   alloc      : scan for a free run of size cells, then fill pass
//   erase      : scan all M cells (read, compare, write back)
//   defragment : compact pass over M cells, then zero the tail
// Alloc with a spent identifier counter or a size of 0 or above M, and erase of
// identifier 0, answer at once without a scan. Erase that hits a cell and
// defragment give no result. The result sits in an output register: a stalled
// receiver does not stop the next request from being taken, only the
// completion of a request that has a result to hand over.
// After reset the block clears all CELLS table entries, one per cycle, and
// takes no request until the clear is done; configuration writes go through at
// any time. memory_cells (i_cfg_we/i_cfg_wdata) clamps to 1..CELLS and resets
// to 128 limited to CELLS.
module first_fit_cell_allocator import ffca_pkg::*; #(
    parameter int unsigned CELLS   = 128,
    parameter int unsigned ID_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    ffca_req_if.sink          i_req,
    ffca_rsp_if.source        o_rsp
);

    localparam int unsigned CW = $clog2(CELLS + 1);
    localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int unsigned MC_RST = (CELLS < 128) ? CELLS : 128;

    t_state_e          r_state, n_state;
    logic [CW-1:0]     r_mc, n_mc;
    logic [ID_BITS-1:0] r_next_id, n_next_id;
    logic [CW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_vld, n_vld;
    logic [CW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_run, n_run;
    logic [CW-1:0]     r_start, n_start;
    logic [CW-1:0]     r_fill, n_fill;
    logic [CW-1:0]     r_end, n_end;
    logic [CW-1:0]     r_dst, n_dst;
    logic              r_found, n_found;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [BID_W-1:0]  r_bid, n_bid;
    t_status_e         r_res_status, n_res_status;
    logic [BID_W-1:0]  r_res_id, n_res_id;
    logic              r_out_vld, n_out_vld;
    t_status_e         r_out_status, n_out_status;
    logic [BID_W-1:0]  r_out_id, n_out_id;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ID_BITS-1:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ID_BITS-1:0] wr_data;

    logic [CW-1:0] cfg_mc;
    logic          last;
    logic          match;
    logic [31:0]   id_ext;

    ffca_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (ID_BITS)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_mc = CW'(1);
        end else if (32'(i_cfg_wdata) > 32'(CELLS)) begin
            cfg_mc = CW'(CELLS);
        end else begin
            cfg_mc = CW'(i_cfg_wdata);
        end
    end

    assign last   = (r_j == r_mc - CW'(1));
    assign match  = (32'(rd_data) == 32'(r_bid));
    assign id_ext = 32'(r_next_id);

    always_comb begin
        n_state      = r_state;
        n_mc         = r_mc;
        n_next_id    = r_next_id;
        n_rd_idx     = r_rd_idx;
        n_vld        = 1'b0;
        n_j          = r_j;
        n_run        = r_run;
        n_start      = r_start;
        n_fill       = r_fill;
        n_end        = r_end;
        n_dst        = r_dst;
        n_found      = r_found;
        n_size       = r_size;
        n_bid        = r_bid;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_out_vld    = r_out_vld;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        rd_en        = 1'b0;
        rd_addr      = r_rd_idx[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_fill[AW-1:0];
        wr_data      = '0;
        i_req.ready  = 1'b0;

        if (i_cfg_we) begin
            n_mc = cfg_mc;
        end
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        if (r_state == S_ASCAN || r_state == S_ESCAN || r_state == S_DSCAN) begin
            rd_en = (r_rd_idx < r_mc);
            n_vld = rd_en;
            n_j   = r_rd_idx;
            if (rd_en) begin
                n_rd_idx = r_rd_idx + CW'(1);
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_fill[AW-1:0];
                n_fill  = r_fill + CW'(1);
                if (r_fill == CW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_rd_idx = '0;
                    n_run    = '0;
                    n_found  = 1'b0;
                    n_dst    = '0;
                    n_size   = i_req.block_size;
                    n_bid    = i_req.block_id;
                    n_res_id = '0;
                    unique case (i_req.req_type)
                        REQ_ALLOC: begin
                            if (r_next_id == '0 || i_req.block_size == '0 ||
                                32'(i_req.block_size) > 32'(r_mc)) begin
                                n_res_status = ST_NULL;
                                n_state      = S_RESP;
                            end else begin
                                n_state = S_ASCAN;
                            end
                        end
                        REQ_ERASE: begin
                            if (i_req.block_id == '0) begin
                                n_res_status = ST_ILLEGAL;
                                n_state      = S_RESP;
                            end else begin
                                n_state = S_ESCAN;
                            end
                        end
                        REQ_DEFRAG: begin
                            n_state = S_DSCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ASCAN: begin
                if (r_vld) begin
                    if (rd_data == '0) begin
                        if (32'(r_run) + 32'd1 == 32'(r_size)) begin
                            n_fill  = (r_run == '0) ? r_j : r_start;
                            n_end   = r_j;
                            n_state = S_AFILL;
                        end else begin
                            n_run = r_run + CW'(1);
                            if (r_run == '0) begin
                                n_start = r_j;
                            end
                            if (last) begin
                                n_res_status = ST_NULL;
                                n_state      = S_RESP;
                            end
                        end
                    end else begin
                        n_run = '0;
                        if (last) begin
                            n_res_status = ST_NULL;
                            n_state      = S_RESP;
                        end
                    end
                end
            end
            S_AFILL: begin
                wr_en   = 1'b1;
                wr_addr = r_fill[AW-1:0];
                wr_data = r_next_id;
                n_fill  = r_fill + CW'(1);
                if (r_fill == r_end) begin
                    n_next_id    = r_next_id + ID_BITS'(1);
                    n_res_status = ST_OK;
                    n_res_id     = id_ext[BID_W-1:0];
                    n_state      = S_RESP;
                end
            end
            S_ESCAN: begin
                if (r_vld) begin
                    if (match) begin
                        wr_en   = 1'b1;
                        wr_addr = r_j[AW-1:0];
                        n_found = 1'b1;
                    end
                    if (last) begin
                        if (!(r_found || match)) begin
                            n_res_status = ST_ILLEGAL;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_DSCAN: begin
                if (r_vld) begin
                    if (rd_data != '0) begin
                        wr_en   = 1'b1;
                        wr_addr = r_dst[AW-1:0];
                        wr_data = rd_data;
                        n_dst   = r_dst + CW'(1);
                    end
                    if (last) begin
                        n_fill  = n_dst;
                        n_state = S_DZERO;
                    end
                end
            end
            S_DZERO: begin
                if (r_fill < r_mc) begin
                    wr_en   = 1'b1;
                    wr_addr = r_fill[AW-1:0];
                    n_fill  = r_fill + CW'(1);
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_mc      <= CW'(MC_RST);
            r_next_id <= ID_BITS'(1);
            r_fill    <= '0;
            r_vld     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mc      <= n_mc;
            r_next_id <= n_next_id;
            r_fill    <= n_fill;
            r_vld     <= n_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_j          <= n_j;
        r_run        <= n_run;
        r_start      <= n_start;
        r_end        <= n_end;
        r_dst        <= n_dst;
        r_found      <= n_found;
        r_size       <= n_size;
        r_bid        <= n_bid;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
    end

    assign o_rsp.valid    = r_out_vld;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.given_id = r_out_id;

endmodule
